### design/assert_macros.svh
// assertion helpers used by the engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CHTE_ASSERT_NEVER(lbl, cond, msg) \
  `CHTE_ASSERT(lbl, !(cond), msg)
`else
`define CHTE_ASSERT(lbl, prop, msg)
`define CHTE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### design/chte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// types, codes and defaults for the chained hash table engine
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int unsigned DefBuckets  = 64;
  localparam int unsigned DefNodes    = 128;
  localparam int unsigned DefKeyBytes = 8;
  localparam logic [6:0]  BucketCountReset = 7'd64;
  localparam int unsigned HashWidth   = 32;
  localparam int unsigned BitsPerStep = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_HLOOK,
    ST_NRD,
    ST_NCHK,
    ST_ACT,
    ST_ALLOC,
    ST_RES
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key_bytes;
    logic [3:0]         key_length;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic               success;
    logic signed [31:0] value_out;
    logic               pool_full;
    logic [7:0]         entry_count;
    logic [6:0]         used_buckets;
    logic               table_empty;
  } out_t;

endpackage

### design/chte_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_hash
// folding hash of the key followed by a two-bit-per-cycle modulo unit
// ----------------------------------------------------------------------------
module chte_hash #(
  parameter int unsigned BUCKETS   = chte_pkg::DefBuckets,
  parameter int unsigned KEY_BYTES = chte_pkg::DefKeyBytes
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [63:0]                      key_i,
  input  logic [3:0]                       len_i,
  input  logic [$clog2(BUCKETS+1)-1:0]     modulus_i,
  output logic                             done_o,
  output logic [(BUCKETS>1 ? $clog2(BUCKETS) : 1)-1:0] bucket_o
);

  localparam int unsigned CW    = $clog2(BUCKETS + 1);
  localparam int unsigned BKW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int unsigned HW    = chte_pkg::HashWidth;
  localparam int unsigned STEPS = HW / chte_pkg::BitsPerStep;
  localparam int unsigned SCW   = $clog2(STEPS + 1);

  logic [HW-1:0]  sum;
  logic [HW-1:0]  div_q, div_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic [CW-1:0]  mod_q;
  logic [SCW-1:0] cnt_q;
  logic           busy_q, done_q;
  logic [CW:0]    part;

  // sign-extended bytes at rotating byte offsets
  always_comb begin
    sum = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (32'(len_i) > i) begin
        sum = sum + ({{(HW-8){key_i[8*i+7]}}, key_i[8*i +: 8]} << (8 * (i % 4)));
      end
    end
  end

  // restoring remainder, two dividend bits a cycle
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    part  = '0;
    for (int s = 0; s < chte_pkg::BitsPerStep; s++) begin
      part  = {rem_d, div_d[HW-1]};
      div_d = {div_d[HW-2:0], 1'b0};
      if (part >= {1'b0, mod_q}) begin
        part = part - {1'b0, mod_q};
      end
      rem_d = part[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (32'(cnt_q) == STEPS - 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= sum;
      rem_q <= '0;
      mod_q <= modulus_i;
    end else if (busy_q) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[BKW-1:0];

endmodule

### design/chte_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_free_list
// stack of free node indexes in a memory, untouched slots read as their index
// ----------------------------------------------------------------------------
module chte_free_list #(
  parameter int unsigned NODES = chte_pkg::DefNodes
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       pop_i,
  input  logic                                       push_i,
  input  logic [(NODES>1 ? $clog2(NODES) : 1)-1:0]   push_idx_i,
  output logic [$clog2(NODES+1)-1:0]                 count_o,
  output logic [(NODES>1 ? $clog2(NODES) : 1)-1:0]   pop_idx_o
);

  localparam int unsigned NW  = NODES > 1 ? $clog2(NODES) : 1;
  localparam int unsigned FCW = $clog2(NODES + 1);

  logic [NW-1:0]  mem [NODES];
  logic [FCW-1:0] count_q, low_q;
  logic [NW-1:0]  rd_addr;
  logic [NW-1:0]  rdata_q, raddr_q;
  logic           fresh_q;
  logic [FCW-1:0] count_dec;

  assign count_dec = count_q - 1'b1;
  assign rd_addr   = count_dec[NW-1:0];

  // low mark: slots at or above it have been popped since reset and read from memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= FCW'(NODES);
      low_q   <= FCW'(NODES);
    end else if (pop_i) begin
      count_q <= count_dec;
      if (count_dec < low_q) begin
        low_q <= count_dec;
      end
    end else if (push_i) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !pop_i) begin
      mem[count_q[NW-1:0]] <= push_idx_i;
    end
    if (pop_i) begin
      rdata_q <= mem[rd_addr];
      raddr_q <= rd_addr;
      fresh_q <= count_dec < low_q;
    end
  end

  assign count_o   = count_q;
  assign pop_idx_o = fresh_q ? raddr_q : rdata_q;

endmodule

### design/chained_hash_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// key-value store with separate chaining over a fixed node pool
// ----------------------------------------------------------------------------
// One command at a time: insert/overwrite, delete or get on a key of up to
// eight bytes. The key is folded into a 32-bit hash and reduced modulo the
// bucket count by a divider retiring two bits a cycle. The head of the
// selected bucket is then read, and the chain is walked with a synchronous
// node memory read, then a compare, for each node visited. An insert of a
// new key adds an allocation step. The user must write the bucket count
// register only while the engine is idle; the block itself does not
// enforce it. The result beat sits in an output register so a new
// command can be taken while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chained_hash_table_engine #(
  parameter int unsigned BUCKETS   = chte_pkg::DefBuckets,
  parameter int unsigned NODES     = chte_pkg::DefNodes,
  parameter int unsigned KEY_BYTES = chte_pkg::DefKeyBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  chte_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output chte_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i
);

  localparam int unsigned CW  = $clog2(BUCKETS + 1);
  localparam int unsigned BKW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW  = NODES > 1 ? $clog2(NODES) : 1;
  localparam int unsigned FCW = $clog2(NODES + 1);

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] value;
    logic [NW-1:0] next;
    logic        nvld;
  } node_t;

  chte_pkg::state_e state_q, state_d;

  // configuration
  logic [6:0]    bcount_q;
  logic [CW-1:0] bc_eff;

  // command
  chte_pkg::cmd_e cmd_q;
  logic [63:0]    key_q, key_m;
  logic [3:0]     len_q, len_s;
  logic [31:0]    val_q;

  // hashing
  logic           hash_done;
  logic [BKW-1:0] hash_bucket;
  logic [BKW-1:0] bucket_q;

  // memories
  logic [NW-1:0] head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld_q;
  logic [NW-1:0] head_rd_q;
  node_t         node_mem [NODES];
  node_t         node_rd_q;

  // walk
  logic [NW-1:0]  cur_q, prev_q;
  node_t          cur_ent_q, prev_ent_q;
  logic           have_prev_q, found_q;
  logic [FCW-1:0] steps_q;
  logic           match;

  // counts and result
  logic [FCW-1:0] entries_q;
  logic [CW-1:0]  used_q;
  logic           succ_q, full_q;
  logic [31:0]    vout_q;
  logic           out_valid_q;
  chte_pkg::out_t out_q;

  // free list
  logic           fl_pop, fl_push;
  logic [FCW-1:0] fl_count;
  logic [NW-1:0]  fl_idx;

  // write strobes
  logic          node_we, head_we;
  logic [NW-1:0] node_waddr, head_wdata;
  node_t         node_wdata;
  logic          head_wvld;
  logic          res_load;

  // bucket count clamped to 1..BUCKETS
  always_comb begin
    if (bcount_q == '0) begin
      bc_eff = CW'(1);
    end else if (32'(bcount_q) > BUCKETS) begin
      bc_eff = CW'(BUCKETS);
    end else begin
      bc_eff = CW'(bcount_q);
    end
  end

  // saturate length and clear bytes past it
  always_comb begin
    len_s = (32'(in_data_i.key_length) > KEY_BYTES) ? 4'(KEY_BYTES)
                                                    : in_data_i.key_length;
    key_m = '0;
    for (int i = 0; i < 8; i++) begin
      if (32'(len_s) > i) begin
        key_m[8*i +: 8] = in_data_i.key_bytes[8*i +: 8];
      end
    end
  end

  assign in_ready_o = (state_q == chte_pkg::ST_IDLE);

  chte_hash #(
    .BUCKETS   (BUCKETS),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_valid_i && in_ready_o),
    .key_i     (key_m),
    .len_i     (len_s),
    .modulus_i (bc_eff),
    .done_o    (hash_done),
    .bucket_o  (hash_bucket)
  );

  chte_free_list #(
    .NODES (NODES)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_i      (fl_pop),
    .push_i     (fl_push),
    .push_idx_i (cur_q),
    .count_o    (fl_count),
    .pop_idx_o  (fl_idx)
  );

  assign match = (node_rd_q.len == len_q) && (node_rd_q.key == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chte_pkg::ST_IDLE:  if (in_valid_i) state_d = chte_pkg::ST_HASH;
      chte_pkg::ST_HASH:  if (hash_done) state_d = chte_pkg::ST_HEAD;
      chte_pkg::ST_HEAD:  state_d = chte_pkg::ST_HLOOK;
      chte_pkg::ST_HLOOK: state_d = head_vld_q[bucket_q] ? chte_pkg::ST_NRD
                                                         : chte_pkg::ST_ACT;
      chte_pkg::ST_NRD:   state_d = chte_pkg::ST_NCHK;
      chte_pkg::ST_NCHK: begin
        if (!match && node_rd_q.nvld && (32'(steps_q) + 32'd1 < NODES)) begin
          state_d = chte_pkg::ST_NRD;
        end else begin
          state_d = chte_pkg::ST_ACT;
        end
      end
      chte_pkg::ST_ACT: begin
        if (cmd_q == chte_pkg::CMD_INSERT && !found_q && fl_count != '0) begin
          state_d = chte_pkg::ST_ALLOC;
        end else begin
          state_d = chte_pkg::ST_RES;
        end
      end
      chte_pkg::ST_ALLOC: state_d = chte_pkg::ST_RES;
      chte_pkg::ST_RES:   if (!out_valid_q || out_ready_i) state_d = chte_pkg::ST_IDLE;
      default:            state_d = chte_pkg::ST_IDLE;
    endcase
  end

  // memory strobes per state
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cur_q;
    node_wdata = cur_ent_q;
    head_we    = 1'b0;
    head_wdata = cur_ent_q.next;
    head_wvld  = cur_ent_q.nvld;
    fl_pop     = 1'b0;
    fl_push    = 1'b0;
    res_load   = 1'b0;
    unique case (state_q)
      chte_pkg::ST_ACT: begin
        case (cmd_q)
          chte_pkg::CMD_INSERT: begin
            if (found_q) begin
              node_we          = 1'b1;
              node_wdata.value = val_q;
            end else if (fl_count != '0) begin
              fl_pop = 1'b1;
            end
          end
          chte_pkg::CMD_DELETE: begin
            if (found_q) begin
              if (have_prev_q) begin
                node_we         = 1'b1;
                node_waddr      = prev_q;
                node_wdata      = prev_ent_q;
                node_wdata.next = cur_ent_q.next;
                node_wdata.nvld = cur_ent_q.nvld;
              end else begin
                head_we = 1'b1;
              end
              fl_push = (fl_count < FCW'(NODES));
            end
          end
          default: ;
        endcase
      end
      chte_pkg::ST_ALLOC: begin
        node_we    = 1'b1;
        node_waddr = fl_idx;
        node_wdata = '{key: key_q, len: len_q, value: val_q, next: head_rd_q,
                       nvld: head_vld_q[bucket_q]};
        head_we    = 1'b1;
        head_wdata = fl_idx;
        head_wvld  = 1'b1;
      end
      chte_pkg::ST_RES: res_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // synchronous memories, registered read
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[cur_q];
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    head_rd_q <= head_mem[bucket_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chte_pkg::ST_IDLE;
      bcount_q    <= chte_pkg::BucketCountReset;
      head_vld_q  <= '0;
      entries_q   <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bcount_q <= cfg_wdata_i;
      end
      if (head_we) begin
        head_vld_q[bucket_q] <= head_wvld;
      end
      // bucket fills on insert into empty head, empties on delete of its only node
      if (state_q == chte_pkg::ST_ALLOC) begin
        entries_q <= entries_q + 1'b1;
        if (!head_vld_q[bucket_q]) begin
          used_q <= used_q + 1'b1;
        end
      end else if (state_q == chte_pkg::ST_ACT && cmd_q == chte_pkg::CMD_DELETE
                   && found_q) begin
        entries_q <= entries_q - 1'b1;
        if (!have_prev_q && !cur_ent_q.nvld) begin
          used_q <= used_q - 1'b1;
        end
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and walk datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      chte_pkg::ST_IDLE: begin
        cmd_q       <= chte_pkg::cmd_e'(in_data_i.cmd);
        key_q       <= key_m;
        len_q       <= len_s;
        val_q       <= in_data_i.value_in;
        have_prev_q <= 1'b0;
        found_q     <= 1'b0;
        steps_q     <= '0;
        succ_q      <= 1'b0;
        full_q      <= 1'b0;
        vout_q      <= '1;
      end
      chte_pkg::ST_HASH:  if (hash_done) bucket_q <= hash_bucket;
      chte_pkg::ST_HLOOK: cur_q <= head_rd_q;
      chte_pkg::ST_NCHK: begin
        steps_q <= steps_q + 1'b1;
        if (match) begin
          found_q   <= 1'b1;
          cur_ent_q <= node_rd_q;
        end else begin
          prev_q      <= cur_q;
          prev_ent_q  <= node_rd_q;
          have_prev_q <= 1'b1;
          cur_q       <= node_rd_q.next;
        end
      end
      chte_pkg::ST_ACT: begin
        case (cmd_q)
          chte_pkg::CMD_INSERT: full_q <= !found_q && (fl_count == '0);
          chte_pkg::CMD_DELETE: succ_q <= found_q;
          chte_pkg::CMD_GET: begin
            succ_q <= found_q;
            if (found_q) begin
              vout_q <= cur_ent_q.value;
            end
          end
          default: ;
        endcase
      end
      chte_pkg::ST_ALLOC: succ_q <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q.success      <= succ_q;
      out_q.value_out    <= vout_q;
      out_q.pool_full    <= full_q;
      out_q.entry_count  <= 8'(entries_q);
      out_q.used_buckets <= 7'(used_q);
      out_q.table_empty  <= (used_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // every node is held, on the free list, or popped and awaiting its link
  `CHTE_ASSERT(a_pool_balance,
    ({1'b0, entries_q} + {1'b0, fl_count} + (FCW+1)'(state_q == chte_pkg::ST_ALLOC)) == (FCW+1)'(NODES),
    "node pool out of balance")
  // a used bucket holds at least one entry
  `CHTE_ASSERT(a_used_le_entries,
    32'(used_q) <= 32'(entries_q), "more used buckets than entries")
  // the walk never visits more nodes than the pool holds
  `CHTE_ASSERT(a_walk_bound, 32'(steps_q) <= NODES, "chain walk overran pool")
  // a result beat is only loaded once the previous one has gone
  `CHTE_ASSERT_NEVER(a_no_overwrite, res_load && out_valid_q && !out_ready_i,
    "result beat overwritten")

endmodule

### verif/tb_chained_hash_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table_engine
// self-checking bench for the chained hash table engine
// ----------------------------------------------------------------------------
// Commands go in through a sender task that also runs a local copy of the
// table (bucket heads, node pool, free stack, counters) and queues the result
// each beat should give. A monitor compares every result beat, field by
// field, with the oldest queued result. Directed tests cover field extremes,
// every command, overwrite, long key lengths, ignored high key bits, bucket
// count limits and pool exhaustion; random phases then run mixed commands
// on a small key set under several idling mixes and bucket counts.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine;

  localparam int unsigned NumBuckets = 64;
  localparam int unsigned NumNodes   = 128;
  localparam int unsigned MaxKey     = 8;
  localparam int unsigned PoolKeys   = 48;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  chte_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  chte_pkg::out_t out_data_o;
  logic           cfg_we_i    = 1'b0;
  logic [6:0]     cfg_wdata_i = '0;

  chained_hash_table_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- table copy
  logic [6:0]  bucket_reg;
  logic [7:0]  head_idx   [NumBuckets];
  logic        head_ok    [NumBuckets];
  logic [63:0] nkey       [NumNodes];
  logic [3:0]  nlen       [NumNodes];
  logic [31:0] nval       [NumNodes];
  logic [7:0]  nnext      [NumNodes];
  logic        nnext_ok   [NumNodes];
  logic [7:0]  free_stack [NumNodes];
  int unsigned free_top;
  int unsigned entries;
  int unsigned used;

  chte_pkg::out_t expected_q[$];

  int errors      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_cfg       = 0;
  int idle_pct    = 0;   // sender idle chance per cycle
  int stall_pct   = 0;   // receiver stall chance per cycle
  int hold_cycles = 0;   // long receiver hold-off, counted down below

  logic [63:0] pool_key [PoolKeys];
  logic [3:0]  pool_len [PoolKeys];

  function automatic logic [63:0] len_mask(int unsigned n);
    return (n >= MaxKey) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // folding hash: sign-extended bytes at 0/8/16/24 bit offsets, wrapping sum
  function automatic logic [31:0] fold_sum(logic [63:0] k, int unsigned n);
    logic [31:0] acc;
    logic [31:0] ch;
    acc = '0;
    for (int unsigned i = 0; i < n; i++) begin
      ch  = {{24{k[8*i+7]}}, k[8*i +: 8]};
      acc = acc + (ch << (8 * (i % 4)));
    end
    return acc;
  endfunction

  task automatic clear_table();
    bucket_reg = chte_pkg::BucketCountReset;
    for (int i = 0; i < NumBuckets; i++) begin
      head_idx[i] = '0;
      head_ok[i]  = 1'b0;
    end
    for (int i = 0; i < NumNodes; i++) begin
      nnext_ok[i]   = 1'b0;
      free_stack[i] = 8'(i);
    end
    free_top = NumNodes;
    entries  = 0;
    used     = 0;
  endtask

  // applies one command to the table copy and gives the result beat
  function automatic chte_pkg::out_t apply_command(chte_pkg::in_t it);
    chte_pkg::out_t r;
    int unsigned    n, bc, b, cur, prev, fresh;
    logic [63:0]    k;
    logic           hit, have_cur, have_prev;
    r = '0;
    r.value_out = -32'sd1;
    n  = (it.key_length > MaxKey) ? MaxKey : it.key_length;
    k  = it.key_bytes & len_mask(n);
    bc = (bucket_reg == 0) ? 1 : ((bucket_reg > NumBuckets) ? NumBuckets : bucket_reg);
    b  = fold_sum(k, n) % bc;
    hit = 1'b0;
    have_prev = 1'b0;
    prev = 0;
    have_cur = head_ok[b];
    cur = head_idx[b];
    for (int s = 0; have_cur && s < NumNodes; s++) begin
      cur = cur % NumNodes;
      if (nlen[cur] == n && nkey[cur] == k) begin
        hit = 1'b1;
        break;
      end
      prev = cur;
      have_prev = 1'b1;
      have_cur = nnext_ok[cur];
      cur = nnext[cur];
    end
    case (chte_pkg::cmd_e'(it.cmd))
      chte_pkg::CMD_INSERT: begin
        if (hit) nval[cur] = it.value_in;
        else if (free_top == 0) r.pool_full = 1'b1;
        else begin
          free_top--;
          fresh = free_stack[free_top] % NumNodes;
          nkey[fresh]     = k;
          nlen[fresh]     = 4'(n);
          nval[fresh]     = it.value_in;
          nnext[fresh]    = head_idx[b];
          nnext_ok[fresh] = head_ok[b];
          if (!head_ok[b]) used++;
          head_idx[b] = 8'(fresh);
          head_ok[b]  = 1'b1;
          entries++;
          r.success = 1'b1;
        end
      end
      chte_pkg::CMD_DELETE: begin
        if (hit) begin
          if (have_prev) begin
            nnext[prev]    = nnext[cur];
            nnext_ok[prev] = nnext_ok[cur];
          end else begin
            head_idx[b] = nnext[cur];
            head_ok[b]  = nnext_ok[cur];
            if (!head_ok[b]) used--;
          end
          nnext_ok[cur] = 1'b0;
          if (free_top < NumNodes) begin
            free_stack[free_top] = 8'(cur);
            free_top++;
          end
          entries--;
          r.success = 1'b1;
        end
      end
      chte_pkg::CMD_GET: begin
        if (hit) begin
          r.value_out = nval[cur];
          r.success   = 1'b1;
        end
      end
      default: ;  // no operation
    endcase
    r.entry_count  = 8'(entries);
    r.used_buckets = 7'(used);
    r.table_empty  = (used == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // offers one beat; valid stays up on return so a following beat can follow
  // straight on, go_quiet or an idle draw in the next call lowers it
  task automatic send_cmd(chte_pkg::cmd_e c, logic [63:0] k, logic [3:0] n,
                          logic [31:0] v);
    chte_pkg::in_t it;
    it.cmd = c;
    it.key_bytes = k;
    it.key_length = n;
    it.value_in = v;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(apply_command(it));
    n_sent++;
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
  endtask

  // lowers valid, then waits for every queued result and a settling margin
  task automatic drain();
    int guard;
    go_quiet();
    guard = 0;
    while (expected_q.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [6:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bucket_reg = v;
    n_cfg++;
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on beat %0d: %s got %0d, expected %0d", n_checked, field, got, want);
    errors++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    chte_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.success !== want.success)
          report_mismatch("success", out_data_o.success, want.success);
        if (out_data_o.value_out !== want.value_out)
          report_mismatch("value_out", out_data_o.value_out, want.value_out);
        if (out_data_o.pool_full !== want.pool_full)
          report_mismatch("pool_full", out_data_o.pool_full, want.pool_full);
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_data_o.entry_count, want.entry_count);
        if (out_data_o.used_buckets !== want.used_buckets)
          report_mismatch("used_buckets", out_data_o.used_buckets, want.used_buckets);
        if (out_data_o.table_empty !== want.table_empty)
          report_mismatch("table_empty", out_data_o.table_empty, want.table_empty);
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------- tests
  // field extremes, every command, overwrite, ignored high bits, long lengths
  task automatic test_directed();
    send_cmd(chte_pkg::CMD_GET,    64'h0, 4'd0, 32'h0);             // get on empty table
    send_cmd(chte_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h8000_0000); // empty key
    send_cmd(chte_pkg::CMD_GET,    64'h0, 4'd0, 32'h0);
    send_cmd(chte_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h7FFF_FFFF);
    send_cmd(chte_pkg::CMD_GET,    64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0); // length saturates
    send_cmd(chte_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'hFFFF_FFFF); // overwrite
    send_cmd(chte_pkg::CMD_GET,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_cmd(chte_pkg::CMD_INSERT, 64'h1234_5678_9ABC_0041, 4'd1, 32'd5); // high bits ignored
    send_cmd(chte_pkg::CMD_GET,    64'h0000_0000_0000_0041, 4'd1, 32'd0);
    send_cmd(chte_pkg::CMD_GET,    64'h0000_0000_0000_0041, 4'd2, 32'd0); // length differs
    send_cmd(chte_pkg::CMD_INSERT, 64'h8080_8080_8080_8080, 4'd7, 32'd0); // sign-extended bytes
    send_cmd(chte_pkg::CMD_NOP,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd9);
    send_cmd(chte_pkg::CMD_DELETE, 64'hDEAD_BEEF_0000_0041, 4'd1, 32'd0);
    send_cmd(chte_pkg::CMD_DELETE, 64'h0000_0000_0000_0041, 4'd1, 32'd0); // already gone
    send_cmd(chte_pkg::CMD_GET,    64'h0000_0000_0000_0041, 4'd1, 32'd0);
    send_cmd(chte_pkg::CMD_DELETE, 64'h0, 4'd0, 32'd0);
    send_cmd(chte_pkg::CMD_DELETE, 64'h0000_FFFF_FFFF_FFFF, 4'd8, 32'd0); // near miss
    send_cmd(chte_pkg::CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'd0);
    send_cmd(chte_pkg::CMD_DELETE, 64'h0080_8080_8080_8080, 4'd7, 32'd0); // table empty again
    drain();
  endtask

  // single bucket so one long chain, then exhaust the node pool and free it
  task automatic test_pool_full();
    write_buckets(7'd0);
    for (int i = 0; i <= NumNodes; i++)
      send_cmd(chte_pkg::CMD_INSERT, {32'hC3A5_5A3C, 32'(i)}, 4'd8, $urandom);
    send_cmd(chte_pkg::CMD_INSERT, {32'hC3A5_5A3C, 32'd3}, 4'd8, 32'd77); // overwrite when full
    send_cmd(chte_pkg::CMD_GET, {32'hC3A5_5A3C, 32'd0}, 4'd8, 32'd0);     // deep in the chain
    for (int i = 0; i <= NumNodes; i++)
      send_cmd(chte_pkg::CMD_DELETE, {32'hC3A5_5A3C, 32'(i)}, 4'd8, 32'd0);
    drain();
  endtask

  task automatic fill_key_set();
    for (int i = 0; i < PoolKeys; i++) begin
      pool_len[i] = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                             : 4'($urandom_range(8));
      pool_key[i] = {$urandom, $urandom};
    end
  endtask

  task automatic random_cmds(int count);
    int             pick, j, sel;
    chte_pkg::cmd_e c;
    logic [63:0]    k;
    logic [3:0]     n;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      c = (pick < 45) ? chte_pkg::CMD_INSERT : (pick < 67) ? chte_pkg::CMD_DELETE :
          (pick < 95) ? chte_pkg::CMD_GET : chte_pkg::CMD_NOP;
      sel = $urandom_range(9);
      if (sel < 8) begin
        // known key with junk above its length
        j = $urandom_range(PoolKeys - 1);
        n = pool_len[j];
        k = (pool_key[j] & len_mask(n)) | ({$urandom, $urandom} & ~len_mask(n));
      end else begin
        n = 4'($urandom_range(15));
        k = {$urandom, $urandom};
      end
      send_cmd(c, k, n, $urandom);
    end
  endtask

  // random phases across idling mixes and bucket counts, changes made with
  // entries still held so some of them go out of reach
  task automatic test_random();
    int idle_mix  [4] = '{0, 66, 0, 23};
    int stall_mix [4] = '{0, 0, 66, 23};
    logic [6:0] counts [4] = '{7'd64, 7'd7, 7'd127, 7'd33};
    fill_key_set();
    for (int p = 0; p < 4; p++) begin
      write_buckets(counts[p]);
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      random_cmds(90);
      write_buckets(7'd1);
      random_cmds(60);
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain();
  endtask

  // long receiver hold-off while beats keep coming, so the input side stalls
  task automatic test_backpressure();
    write_buckets(7'd64);
    hold_cycles = 600;
    random_cmds(20);
    drain();
  endtask

  initial begin
    clear_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pool_full();
    test_random();
    test_backpressure();
    drain();
    $display("ran %0d commands, checked %0d result beats, %0d bucket count writes",
             n_sent, n_checked, n_cfg);
    $display("covered all commands, pool exhaustion, long chains and stalls on both sides");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (expected_q.size() != 0) $display("%0d results never arrived", expected_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #80_000_000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/chte_pkg.sv
design/chte_hash.sv
design/chte_free_list.sv
design/chained_hash_table_engine.sv
verif/tb_chained_hash_table_engine.sv
